// ===== hdl/lcd4_pkg.sv =====
// ----------------------------------------------------------------------------
// lcd4_pkg
// shared types, constants and the microcode table of the 4-bit lcd sequencer
// ----------------------------------------------------------------------------
package lcd4_pkg;

  localparam int unsigned NUM_ROWS = 4;
  localparam logic [1:0]  ROW_MAX  = 2'(NUM_ROWS - 1);

  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_POS  = 2'd2;
  localparam logic [1:0] MODE_PWR  = 2'd3;

  localparam logic [15:0] CYCLES_PER_MS_RST = 16'd16000;

  localparam logic [6:0] HOLD_NONE    = 7'd0;
  localparam logic [6:0] HOLD_STROBE  = 7'd2;
  localparam logic [6:0] HOLD_SETTLE  = 7'd5;
  localparam logic [6:0] HOLD_POWERUP = 7'd100;

  localparam int unsigned NUM_PWR_CMDS = 7;
  localparam logic [2:0]  PWR_IDX_LAST = 3'(NUM_PWR_CMDS - 1);

  // microcode addresses
  localparam logic [2:0] PC_PWR_WAIT  = 3'd0;
  localparam logic [2:0] PC_BYTE_HEAD = 3'd1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] value;
    logic [1:0] row;
    logic [5:0] col;
  } in_item_t;

  typedef struct packed {
    logic       rs;
    logic       enable;
    logic [3:0] nibble;
    logic [6:0] hold_ms;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    NIB_ZERO,
    NIB_HIGH,
    NIB_LOW
  } nib_sel_e;

  // one control word per microcode step
  typedef struct packed {
    logic       en;
    nib_sel_e   nib_sel;
    logic [6:0] hold;
    logic       byte_end;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input logic [2:0] pc);
    ctrl_t w;
    unique case (pc)
      3'd0:    w = '{en: 1'b0, nib_sel: NIB_ZERO, hold: HOLD_POWERUP, byte_end: 1'b0};
      3'd1:    w = '{en: 1'b0, nib_sel: NIB_HIGH, hold: HOLD_NONE,    byte_end: 1'b0};
      3'd2:    w = '{en: 1'b1, nib_sel: NIB_HIGH, hold: HOLD_STROBE,  byte_end: 1'b0};
      3'd3:    w = '{en: 1'b0, nib_sel: NIB_LOW,  hold: HOLD_NONE,    byte_end: 1'b0};
      3'd4:    w = '{en: 1'b1, nib_sel: NIB_LOW,  hold: HOLD_STROBE,  byte_end: 1'b0};
      3'd5:    w = '{en: 1'b0, nib_sel: NIB_LOW,  hold: HOLD_SETTLE,  byte_end: 1'b1};
      default: w = '{en: 1'b0, nib_sel: NIB_ZERO, hold: HOLD_NONE,    byte_end: 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pwr_cmd(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h28;
      3'd3:    c = 8'h0C;
      3'd4:    c = 8'h02;
      3'd5:    c = 8'h01;
      default: c = 8'h06;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/lcd_4bit_write_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// lcd_4bit_write_sequencer_core
// microcoded sequencer turning lcd requests into timed 4-bit bus phases
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  -----------------------------
//  in       sink       in_valid_i/in_stall_o  in_item_i  (mode,value,row,col)
//  out      source     out_valid_o/out_stall_i out_item_o (rs,enable,nibble,
//                                                          hold_ms,last)
//  cfg      sink       cfg_we_i               cfg_wdata_i (cycles_per_ms)
//
// - one item per request; a byte gives five phase items and nine ms of hold,
//   so a command, data or position request holds the bus for nine ms plus
//   the output handshake of each phase
// - a power-up request gives 36 items and 163 ms of hold
// - the hold timer (ms counter and cycles-per-ms prescaler) paces every hold
// - reset clears the sequencer to idle and cycles_per_ms to 16000
// - an output stall freezes the step counter; the hold starts once the
//   phase item is taken, and in_stall_o is high until the final hold ends
//
module lcd_4bit_write_sequencer_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lcd4_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lcd4_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);
  import lcd4_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_HOLD
  } state_e;

  state_e      state_q;
  logic [2:0]  pc_q;         // microcode step counter
  logic [7:0]  byte_q;       // byte being sent
  logic        rs_q;         // register select of that byte
  logic        pwr_q;        // power-up program running
  logic [2:0]  cmd_idx_q;    // index into the power-up command list
  logic [6:0]  ms_q;         // remaining hold in ms
  logic [15:0] cyc_q;        // cycles within the current ms
  logic [15:0] cpm_q;        // cycles_per_ms register

  ctrl_t       ctrl;
  logic        more_bytes;
  logic        out_fire;
  logic        in_fire;
  logic        ms_tick;

  // advance result
  logic        adv_done;
  logic [2:0]  adv_pc;
  logic [7:0]  adv_byte;
  logic [2:0]  adv_idx;

  // request decode
  logic [1:0]  row_sat;
  logic [7:0]  req_byte;
  logic        req_rs;

  assign ctrl       = ucode_rom(pc_q);
  assign more_bytes = pwr_q && (cmd_idx_q != PWR_IDX_LAST);
  assign out_fire   = out_valid_o && !out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign ms_tick    = (cyc_q == (cpm_q - 16'd1));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  // phase levels straight from the control word and the byte register
  always_comb begin
    out_item_o.rs      = rs_q;
    out_item_o.enable  = ctrl.en;
    out_item_o.hold_ms = ctrl.hold;
    out_item_o.last    = ctrl.byte_end && !more_bytes;
    unique case (ctrl.nib_sel)
      NIB_HIGH: out_item_o.nibble = byte_q[7:4];
      NIB_LOW:  out_item_o.nibble = byte_q[3:0];
      default:  out_item_o.nibble = 4'h0;
    endcase
  end

  // next step: fall through, or loop back to the byte head for the next
  // power-up command, or finish
  always_comb begin
    adv_done = 1'b0;
    adv_pc   = pc_q + 3'd1;
    adv_byte = byte_q;
    adv_idx  = cmd_idx_q;
    if (ctrl.byte_end) begin
      if (more_bytes) begin
        adv_pc   = PC_BYTE_HEAD;
        adv_idx  = cmd_idx_q + 3'd1;
        adv_byte = pwr_cmd(cmd_idx_q + 3'd1);
      end else begin
        adv_done = 1'b1;
      end
    end
  end

  // byte and register select of a new request
  always_comb begin
    row_sat  = (in_item_i.row > ROW_MAX) ? ROW_MAX : in_item_i.row;
    req_rs   = 1'b0;
    req_byte = in_item_i.value;
    unique case (in_item_i.mode)
      MODE_CMD:  req_byte = in_item_i.value;
      MODE_DATA: req_rs   = 1'b1;
      MODE_POS:  req_byte = row_base(row_sat) + {2'b00, in_item_i.col};
      default:   req_byte = pwr_cmd(3'd0);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= '0;
      byte_q    <= '0;
      rs_q      <= 1'b0;
      pwr_q     <= 1'b0;
      cmd_idx_q <= '0;
      ms_q      <= '0;
      cyc_q     <= '0;
      cpm_q     <= CYCLES_PER_MS_RST;
    end else begin
      if (cfg_we_i) begin
        cpm_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q   <= ST_EMIT;
            byte_q    <= req_byte;
            rs_q      <= req_rs;
            pwr_q     <= (in_item_i.mode == MODE_PWR);
            cmd_idx_q <= '0;
            pc_q      <= (in_item_i.mode == MODE_PWR) ? PC_PWR_WAIT : PC_BYTE_HEAD;
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            if (ctrl.hold != HOLD_NONE) begin
              state_q <= ST_HOLD;
              ms_q    <= ctrl.hold;
              cyc_q   <= '0;
            end else if (adv_done) begin
              state_q <= ST_IDLE;
            end else begin
              pc_q      <= adv_pc;
              byte_q    <= adv_byte;
              cmd_idx_q <= adv_idx;
            end
          end
        end
        ST_HOLD: begin
          if (ms_tick) begin
            cyc_q <= '0;
            if (ms_q == 7'd1) begin
              if (adv_done) begin
                state_q <= ST_IDLE;
              end else begin
                state_q   <= ST_EMIT;
                pc_q      <= adv_pc;
                byte_q    <= adv_byte;
                cmd_idx_q <= adv_idx;
              end
            end else begin
              ms_q <= ms_q - 7'd1;
            end
          end else begin
            cyc_q <= cyc_q + 16'd1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/lcd4_bus_checker.sv =====
// ----------------------------------------------------------------------------
// lcd4_bus_checker
// watches the request and bus-phase channels, predicts every phase item
// and compares it field by field against what the sequencer emits
// ----------------------------------------------------------------------------
module lcd4_bus_checker
  import lcd4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // ddram addresses of the row starts, row 0 in the low byte
  localparam logic [3:0][7:0] ROW_ADDR = {8'hD4, 8'h94, 8'hC0, 8'h80};
  // power-up command bytes, first one in the low byte
  localparam logic [6:0][7:0] INIT_SEQ =
    {8'h06, 8'h01, 8'h02, 8'h0C, 8'h28, 8'h32, 8'h33};

  out_item_t   phase_q[$];
  logic [15:0] ms_scale;
  logic [7:0]  last_byte;
  logic        last_select;
  int unsigned mismatches = 0;

  // five bus phases for one byte
  function automatic void push_byte(input logic rs, input logic [7:0] b,
                                    input logic ends_request);
    phase_q.push_back('{rs: rs, enable: 1'b0, nibble: b[7:4], hold_ms: HOLD_NONE,
                        last: 1'b0});
    phase_q.push_back('{rs: rs, enable: 1'b1, nibble: b[7:4], hold_ms: HOLD_STROBE,
                        last: 1'b0});
    phase_q.push_back('{rs: rs, enable: 1'b0, nibble: b[3:0], hold_ms: HOLD_NONE,
                        last: 1'b0});
    phase_q.push_back('{rs: rs, enable: 1'b1, nibble: b[3:0], hold_ms: HOLD_STROBE,
                        last: 1'b0});
    phase_q.push_back('{rs: rs, enable: 1'b0, nibble: b[3:0], hold_ms: HOLD_SETTLE,
                        last: ends_request});
    last_byte   = b;
    last_select = rs;
  endfunction

  function automatic void predict_request(input in_item_t req);
    logic [1:0] r;
    logic [7:0] addr;
    case (req.mode)
      MODE_CMD:  push_byte(1'b0, req.value, 1'b1);
      MODE_DATA: push_byte(1'b1, req.value, 1'b1);
      MODE_POS: begin
        r    = (req.row > ROW_MAX) ? ROW_MAX : req.row;
        addr = ROW_ADDR[r] + {2'b00, req.col};
        push_byte(1'b0, addr, 1'b1);
      end
      default: begin
        phase_q.push_back('{rs: 1'b0, enable: 1'b0, nibble: 4'h0,
                            hold_ms: HOLD_POWERUP, last: 1'b0});
        for (int i = 0; i < NUM_PWR_CMDS; i++)
          push_byte(1'b0, INIT_SEQ[i], i == NUM_PWR_CMDS - 1);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      phase_q.delete();
      ms_scale    = CYCLES_PER_MS_RST;
      last_byte   = '0;
      last_select = 1'b0;
    end else begin
      if (cfg_we_i)
        ms_scale = cfg_wdata_i;

      if (out_valid_i && !out_stall_i) begin
        if (phase_q.size() == 0) begin
          $error("phase item with nothing expected: %p", out_item_i);
          mismatches++;
        end else begin
          want = phase_q.pop_front();
          if (out_item_i.rs !== want.rs) begin
            $error("rs: expected %0d, got %0d", want.rs, out_item_i.rs);
            mismatches++;
          end
          if (out_item_i.enable !== want.enable) begin
            $error("enable: expected %0d, got %0d", want.enable, out_item_i.enable);
            mismatches++;
          end
          if (out_item_i.nibble !== want.nibble) begin
            $error("nibble: expected %0h, got %0h", want.nibble, out_item_i.nibble);
            mismatches++;
          end
          if (out_item_i.hold_ms !== want.hold_ms) begin
            $error("hold_ms: expected %0d, got %0d", want.hold_ms, out_item_i.hold_ms);
            mismatches++;
          end
          if (out_item_i.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_item_i.last);
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_i)
        predict_request(in_item_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= phase_q.size();
  end

endmodule

// ===== tb/sv/tb_lcd_4bit_write_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// tb_lcd_4bit_write_sequencer_core
// drives lcd requests into the sequencer under random idling on both sides,
// switches the ms prescaler between phases and reports the checker verdict
// ----------------------------------------------------------------------------
module tb_lcd_4bit_write_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lcd4_pkg::*;

  // slowest correct run is dominated by the two prescaler extremes
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned SEG_ITEMS    = 28;
  localparam int unsigned SETTLE_TICKS = 20;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  int unsigned fail_count;
  int unsigned pending_phases;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  lcd_4bit_write_sequencer_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  lcd4_bus_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_phases)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop in case the sequencer hangs or drops a phase item
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // bus side back-pressure, fresh coin every cycle
  always @(posedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // offer one request item, maybe after a random gap, and hold it until taken;
  // valid is left high so back-to-back items need no drop in between
  task automatic send_request(input in_item_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // drop valid, then wait for every phase item and for the final settle hold
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_phases != 0 || in_stall_o) @(posedge clk_i);
  endtask

  // only called with the sequencer idle
  task automatic write_ms_scale(input logic [15:0] cycles);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cycles;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    in_item_t    req;
    int unsigned pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, prescaler set to 1 so the holds stay short
    send_idle_pct = 18;
    recv_idle_pct = 64;
    write_ms_scale(16'd1);
    send_request('{mode: MODE_CMD,  value: 8'h00, row: 2'd0, col: 6'd0});
    // row and col are noise outside position mode
    send_request('{mode: MODE_CMD,  value: 8'hFF, row: 2'd3, col: 6'd63});
    send_request('{mode: MODE_DATA, value: 8'h00, row: 2'd2, col: 6'd42});
    send_request('{mode: MODE_DATA, value: 8'hFF, row: 2'd0, col: 6'd0});
    send_request('{mode: MODE_DATA, value: 8'hA5, row: 2'd1, col: 6'd21});
    send_request('{mode: MODE_CMD,  value: 8'h5A, row: 2'd2, col: 6'd1});
    // every row base, value is ignored here
    send_request('{mode: MODE_POS,  value: 8'hFF, row: 2'd0, col: 6'd0});
    send_request('{mode: MODE_POS,  value: 8'h00, row: 2'd1, col: 6'd63});
    send_request('{mode: MODE_POS,  value: 8'h5A, row: 2'd2, col: 6'd21});
    // last row plus widest column wraps past 0xff
    send_request('{mode: MODE_POS,  value: 8'hA5, row: 2'd3, col: 6'd63});
    send_request('{mode: MODE_POS,  value: 8'h00, row: 2'd3, col: 6'd0});
    // power-up wait and the init commands, all other fields ignored
    send_request('{mode: MODE_PWR,  value: 8'hFF, row: 2'd3, col: 6'd63});
    send_request('{mode: MODE_PWR,  value: 8'h00, row: 2'd0, col: 6'd0});
    send_request('{mode: MODE_CMD,  value: 8'h01, row: 2'd1, col: 6'd42});
    wait_idle();

    // prescaler extremes, one byte each since these give the longest ms
    write_ms_scale(16'd0);
    send_request('{mode: MODE_DATA, value: 8'hC3, row: 2'd0, col: 6'd0});
    wait_idle();
    write_ms_scale(16'hFFFF);
    send_request('{mode: MODE_CMD,  value: 8'h3C, row: 2'd0, col: 6'd0});
    wait_idle();

    // random part in three stretches: slow bus, slow source, then no idling
    for (int seg = 0; seg < 3; seg++) begin
      send_idle_pct = (seg == 0) ? 18 : (seg == 1) ? 64 : 0;
      recv_idle_pct = (seg == 0) ? 64 : (seg == 1) ? 18 : 0;
      write_ms_scale((seg == 0) ? 16'd1 : 16'($urandom_range(2, 8)));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // power-up is long, so keep it to about one item in ten
        pick      = $urandom_range(9);
        req.mode  = (pick < 3) ? MODE_CMD : (pick < 6) ? MODE_DATA :
                    (pick < 9) ? MODE_POS : MODE_PWR;
        req.value = 8'($urandom_range(255));
        req.row   = 2'($urandom_range(3));
        req.col   = 6'($urandom_range(63));
        send_request(req);
      end
      wait_idle();
    end

    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (fail_count == 0 && pending_phases == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lcd4_pkg.sv
hdl/lcd_4bit_write_sequencer_core.sv
tb/sv/lcd4_bus_checker.sv
tb/sv/tb_lcd_4bit_write_sequencer_core.sv
